/* rtl/teav_pkg.sv */
`default_nettype none

package teav_pkg;

  localparam int WordW = 32;
  localparam int CfgIdxW = 8;
  localparam int NumKeys = 4;

  // Round constant added to the running sum once per round.
  localparam logic [WordW-1:0] Delta = 32'hDEADBEEF;

  // Shift amounts of the round function.
  localparam int ShlAmt = 4;
  localparam int ShrAmt = 5;

  // Operation codes carried with each item.
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_KEY0 = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1 = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2 = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3 = 8'd3;

  typedef logic [NumKeys-1:0][WordW-1:0] key_set_t;

  typedef struct packed {
    logic             op;
    logic [WordW-1:0] left;
    logic [WordW-1:0] right;
  } blk_t;

  // TEA style mixing function of one half with the sum and two key words.
  function automatic logic [WordW-1:0] mix(input logic [WordW-1:0] x,
                                           input logic [WordW-1:0] s,
                                           input logic [WordW-1:0] ka,
                                           input logic [WordW-1:0] kb);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    a = (x << ShlAmt) + ka;
    b = x + s;
    c = (x >> ShrAmt) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

`default_nettype wire

/* rtl/teav_in_if.sv */
`default_nettype none

interface teav_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] block_left;
  logic [31:0] block_right;

  modport source (output valid, output op, output block_left, output block_right,
                  input ready);
  modport sink (input valid, input op, input block_left, input block_right,
                output ready);
endinterface

`default_nettype wire

/* rtl/teav_out_if.sv */
`default_nettype none

interface teav_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_left;
  logic [31:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

/* rtl/teav_cfg_if.sv */
`default_nettype none

interface teav_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/teav_key_regs.sv */
`default_nettype none

module teav_key_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  teav_cfg_if.sink               cfg,
  output teav_pkg::key_set_t     keys_o
);
  import teav_pkg::*;

  key_set_t keys_q;
  key_set_t keys_d;
  logic     wr_en;

  assign cfg.ready = 1'b1;
  assign wr_en     = cfg.valid && cfg.ready;

  // Writes to an index past the last key word are dropped.
  always_comb begin
    keys_d = keys_q;
    if (wr_en) begin
      case (cfg.index)
        REG_KEY0: keys_d[0] = cfg.data;
        REG_KEY1: keys_d[1] = cfg.data;
        REG_KEY2: keys_d[2] = cfg.data;
        REG_KEY3: keys_d[3] = cfg.data;
        default:  keys_d = keys_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
    end else begin
      keys_q <= keys_d;
    end
  end

  assign keys_o = keys_q;

endmodule

`default_nettype wire

/* rtl/teav_half_round.sv */
`default_nettype none

module teav_half_round #(
  parameter bit          FIRST_HALF = 1'b1,
  parameter logic [31:0] SUM_ENC    = 32'h0,
  parameter logic [31:0] SUM_DEC    = 32'h0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire teav_pkg::key_set_t keys_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire teav_pkg::blk_t    data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output teav_pkg::blk_t         data_o
);
  import teav_pkg::*;

  logic             valid_q;
  logic             valid_d;
  blk_t             data_q;
  blk_t             data_d;
  logic             load;
  logic             is_dec;
  logic             upd_left;
  logic [WordW-1:0] x;
  logic [WordW-1:0] s;
  logic [WordW-1:0] ka;
  logic [WordW-1:0] kb;
  logic [WordW-1:0] f;
  logic [WordW-1:0] tgt;
  logic [WordW-1:0] res;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Encipher updates left then right within a round; decipher runs the
  // round backwards, so the halves swap roles between the two half rounds.
  assign is_dec   = (data_i.op == OP_DEC);
  assign upd_left = FIRST_HALF ? !is_dec : is_dec;

  always_comb begin
    if (upd_left) begin
      x   = data_i.right;
      tgt = data_i.left;
      ka  = keys_i[0];
      kb  = keys_i[1];
      s   = (is_dec ? SUM_DEC : SUM_ENC) + 32'd1;
    end else begin
      x   = data_i.left;
      tgt = data_i.right;
      ka  = keys_i[2];
      kb  = keys_i[3];
      s   = is_dec ? SUM_DEC : SUM_ENC;
    end
  end

  assign f   = mix(x, s, ka, kb);
  assign res = is_dec ? (tgt - f) : (tgt + f);

  always_comb begin
    data_d = data_i;
    if (upd_left) begin
      data_d.left = res;
    end else begin
      data_d.right = res;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // A held item must not vanish or change while the next stage stalls.
  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q)
    else $error("stage dropped a stalled item");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> $stable(data_q))
    else $error("stage data changed while stalled");

  a_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> valid_q)
    else $error("stage lost an accepted item");

endmodule

`default_nettype wire

/* rtl/tea_variant_block_cipher.sv */
`default_nettype none

// TEA-style 64-bit block cipher with a delta of 0xDEADBEEF and a sum+1 term
// in the left-half update; decipher is the exact inverse of encipher.
// Channels: in_ch takes one item (op, block_left, block_right), op 0
// enciphers and op 1 deciphers; out_ch returns one item (out_left,
// out_right) per input item, in order. cfg_ch writes the four key words at
// indexes 0 to 3; writes to other indexes are ignored and the port is
// always ready. The user must write keys only while no item is in flight;
// the block does not enforce it. Each round is split over two register
// stages, one per half update, so the pipeline is 2*ROUNDS registers deep.
// An accepted item passes through every stage register in order before it
// shows on out_ch. One item enters per cycle while no stage is stalled;
// the depth of the unrolled round pipeline sets the latency.
// Reset clears all stage valid bits and all key words to zero.
// When the receiver stalls, the last stage holds its item and each stage
// still fills any empty slot ahead of it, so input keeps being accepted
// until the whole pipeline is full; nothing is lost or repeated.
module tea_variant_block_cipher #(
  parameter int ROUNDS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  teav_cfg_if.sink   cfg_ch,
  teav_in_if.sink    in_ch,
  teav_out_if.source out_ch
);
  import teav_pkg::*;

  localparam int Stages = 2 * ROUNDS;

  key_set_t keys;
  logic     stg_valid [Stages+1];
  logic     stg_ready [Stages+1];
  blk_t     stg_data  [Stages+1];

  teav_key_regs u_key_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch),
    .keys_o (keys)
  );

  assign stg_valid[0]      = in_ch.valid;
  assign stg_data[0].op    = in_ch.op;
  assign stg_data[0].left  = in_ch.block_left;
  assign stg_data[0].right = in_ch.block_right;
  assign in_ch.ready       = stg_ready[0];

  // Round r uses sum = delta*(r+1) when enciphering and delta*(ROUNDS-r)
  // when deciphering, both taken modulo 2^32 at elaboration.
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam logic [63:0] EncProd = 64'(Delta) * 64'(r + 1);
    localparam logic [63:0] DecProd = 64'(Delta) * 64'(ROUNDS - r);

    for (genvar h = 0; h < 2; h++) begin : g_half
      teav_half_round #(
        .FIRST_HALF (h == 0),
        .SUM_ENC    (EncProd[WordW-1:0]),
        .SUM_DEC    (DecProd[WordW-1:0])
      ) u_half (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .keys_i  (keys),
        .valid_i (stg_valid[2*r+h]),
        .ready_o (stg_ready[2*r+h]),
        .data_i  (stg_data[2*r+h]),
        .valid_o (stg_valid[2*r+h+1]),
        .ready_i (stg_ready[2*r+h+1]),
        .data_o  (stg_data[2*r+h+1])
      );
    end
  end

  // The last stage register doubles as the output register.
  assign out_ch.valid      = stg_valid[Stages];
  assign out_ch.out_left   = stg_data[Stages].left;
  assign out_ch.out_right  = stg_data[Stages].right;
  assign stg_ready[Stages] = out_ch.ready;

endmodule

`default_nettype wire

/* bench/tea_variant_block_cipher_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the TEA-style cipher. Input items come from a queue
// that the stimulus process fills phase by phase. A driver on the falling
// edge offers them, and a monitor on the rising edge records every accepted
// item. For each accepted input item the monitor computes the block that the
// cipher must return and keeps it in a queue. Every accepted output item is
// checked against the oldest block in that queue.
module tea_variant_block_cipher_tb;
  import teav_pkg::*;

  localparam int NumRounds = 32;
  localparam logic [31:0] RoundDelta = 32'hDEADBEEF;

  // The tail after the last item gives any stray output item room to show up.
  localparam int DrainCycles = 150;
  localparam int CycleLimit = 200000;

  // A long stall of the receiver, well past the pipeline depth, is started
  // once this many results have been taken.
  localparam int LongHoldCycles = 300;
  localparam int LongHoldAfter = 60;

  localparam int MaxReports = 10;

  // Indexes outside the key file; the block must ignore writes to them.
  localparam logic [CfgIdxW-1:0] RegUnusedLow = 8'd4;
  localparam logic [CfgIdxW-1:0] RegUnusedHigh = 8'hFF;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } block_halves_t;

  typedef struct {
    logic        op;
    logic [31:0] left;
    logic [31:0] right;
    int unsigned gap;          // idle cycles after this item is taken
    bit          drain_first;  // hold this item back until nothing is in flight
  } cipher_job_t;

  logic clk;
  logic rst_n;

  teav_cfg_if cfg_bus ();
  teav_in_if  in_bus ();
  teav_out_if out_bus ();

  tea_variant_block_cipher #(
    .ROUNDS(NumRounds)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_ch(cfg_bus),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  // Our own copy of the key file, updated when a key write is accepted.
  logic [31:0]   key_copy [NumKeys];

  cipher_job_t   job_queue [$];
  block_halves_t awaited_blocks [$];

  // Handshakes seen at the last rising edge; read by the falling-edge
  // processes to decide what to drive next.
  bit            in_taken;
  bit            out_taken;

  int unsigned   results_seen;
  int unsigned   error_count;
  int unsigned   cycle_count;

  // When set, newly queued items get no gap, so the sender offers them back to back.
  bit            quiet_stretch;

  int unsigned   send_wait;
  cipher_job_t   next_job;

  int unsigned   recv_wait;
  int unsigned   hold_left;
  int unsigned   burst_left;
  int unsigned   stall_draw;
  bit            long_hold_done;

  block_halves_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One round half-update: the mixing of one half with the sum and two keys.
  function automatic logic [31:0] round_mix(logic [31:0] x, logic [31:0] s,
                                            logic [31:0] ka, logic [31:0] kb);
    return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

  // Full cipher with the current key copy. Enciphering adds sum+1 into the
  // left-half update; deciphering undoes the rounds in reverse order,
  // starting from delta times the round count.
  function automatic block_halves_t predict_block(logic op, logic [31:0] lh,
                                                  logic [31:0] rh);
    logic [31:0]   sum;
    block_halves_t res;
    if (op == OP_ENC) begin
      sum = '0;
      for (int r = 0; r < NumRounds; r++) begin
        sum = sum + RoundDelta;
        lh = lh + round_mix(rh, sum + 32'd1, key_copy[0], key_copy[1]);
        rh = rh + round_mix(lh, sum, key_copy[2], key_copy[3]);
      end
    end else begin
      sum = RoundDelta * 32'(NumRounds);
      for (int r = 0; r < NumRounds; r++) begin
        rh = rh - round_mix(lh, sum, key_copy[2], key_copy[3]);
        lh = lh - round_mix(rh, sum + 32'd1, key_copy[0], key_copy[1]);
        sum = sum - RoundDelta;
      end
    end
    res.left = lh;
    res.right = rh;
    return res;
  endfunction

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= MaxReports) begin
      $display("%0t ns: %s", $time, msg);
    end
  endfunction

  // Data words lean toward corners: zero, all ones, a single set bit or a
  // single clear bit; half are plain random.
  function automatic logic [31:0] pick_word();
    logic [31:0] one_hot;
    one_hot = 32'h1 << $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_block(logic op, logic [31:0] lh, logic [31:0] rh, bit drain);
    cipher_job_t job;
    job.op = op;
    job.left = lh;
    job.right = rh;
    job.gap = quiet_stretch ? 0 : $urandom_range(0, 4);
    job.drain_first = drain;
    job_queue.push_back(job);
  endtask

  task automatic queue_both_ops(logic [31:0] lh, logic [31:0] rh);
    queue_block(OP_ENC, lh, rh, 1'b0);
    queue_block(OP_DEC, lh, rh, 1'b0);
  endtask

  // A block followed by the opposite operation on the block that the first
  // one must produce; the second item has to give back the original halves.
  task automatic queue_round_trip(logic op, logic [31:0] lh, logic [31:0] rh);
    block_halves_t mid;
    mid = predict_block(op, lh, rh);
    queue_block(op, lh, rh, 1'b0);
    queue_block(op == OP_ENC ? OP_DEC : OP_ENC, mid.left, mid.right, 1'b0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_key_words(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                               logic [31:0] k3);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
  endtask

  // Returns once every queued item has been taken and every result is back.
  task automatic wait_for_idle();
    do @(posedge clk);
    while (job_queue.size() != 0 || in_bus.valid || awaited_blocks.size() != 0);
  endtask

  // Random items under one key setting. Half of the draws are round trips,
  // the rest single items of either operation. Halfway through, the sender
  // holds one item back until the pipeline has drained completely.
  task automatic run_random_phase(int unsigned count);
    int unsigned made;
    bit          drained;
    logic        op;
    logic [31:0] lh;
    logic [31:0] rh;
    made = 0;
    drained = 1'b0;
    while (made < count) begin
      if ($urandom_range(0, 29) == 0) begin
        quiet_stretch = !quiet_stretch;
      end
      op = $urandom_range(0, 1);
      lh = pick_word();
      rh = pick_word();
      if (!drained && made >= count / 2) begin
        queue_block(op, lh, rh, 1'b1);
        drained = 1'b1;
        made++;
      end else if ($urandom_range(0, 1) == 0) begin
        queue_round_trip(op, lh, rh);
        made += 2;
      end else begin
        queue_block(op, lh, rh, 1'b0);
        made++;
      end
    end
  endtask

  // Sender: offers the next queued item on the falling edge and keeps it up
  // until the block takes it, then idles for the gap drawn for that item.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_wait = 0;
    end else if (in_bus.valid && !in_taken) begin
      // The offer stays up until the block accepts it.
    end else if (send_wait != 0) begin
      in_bus.valid <= 1'b0;
      send_wait--;
    end else if (job_queue.size() != 0 &&
                 !(job_queue[0].drain_first && awaited_blocks.size() != 0)) begin
      next_job = job_queue.pop_front();
      in_bus.valid       <= 1'b1;
      in_bus.op          <= next_job.op;
      in_bus.block_left  <= next_job.left;
      in_bus.block_right <= next_job.right;
      send_wait = next_job.gap;
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // Receiver: after each result it draws a random stall, possibly none, except
  // during bursts where it takes results back to back. Once, it holds ready
  // low for a long stretch so that the pipeline fills and stalls its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
      burst_left = 0;
      long_hold_done = 1'b0;
    end else if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && results_seen >= LongHoldAfter) begin
      long_hold_done = 1'b1;
      hold_left = LongHoldCycles - 1;
      out_bus.ready <= 1'b0;
    end else if (out_bus.ready && out_taken) begin
      if (burst_left != 0) begin
        burst_left--;
        stall_draw = 0;
      end else begin
        stall_draw = $urandom_range(0, 4);
        if ($urandom_range(0, 15) == 0) begin
          burst_left = $urandom_range(10, 40);
        end
      end
      out_bus.ready <= (stall_draw == 0);
      recv_wait = (stall_draw == 0) ? 0 : stall_draw - 1;
    end else if (!out_bus.ready) begin
      if (recv_wait != 0) begin
        recv_wait--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: on the rising edge, tracks key writes, checks output items in
  // order and computes the result of each accepted input item. Results are
  // checked before the new prediction is queued, as they belong to older
  // items.
  always @(posedge clk) begin
    in_taken  = rst_n && in_bus.valid && in_bus.ready;
    out_taken = rst_n && out_bus.valid && out_bus.ready;
    if (!rst_n) begin
      foreach (key_copy[i]) key_copy[i] = '0;
    end else if (cfg_bus.valid && cfg_bus.ready && cfg_bus.index < NumKeys) begin
      key_copy[cfg_bus.index[1:0]] = cfg_bus.data;
    end
    if (out_taken) begin
      results_seen++;
      if (awaited_blocks.size() == 0) begin
        report_error($sformatf("result %h %h with no item in flight",
                               out_bus.out_left, out_bus.out_right));
      end else begin
        want = awaited_blocks.pop_front();
        if (out_bus.out_left !== want.left || out_bus.out_right !== want.right) begin
          report_error($sformatf("left exp %h got %h, right exp %h got %h",
                                 want.left, out_bus.out_left,
                                 want.right, out_bus.out_right));
        end
      end
    end
    if (in_taken) begin
      awaited_blocks.push_back(predict_block(in_bus.op, in_bus.block_left,
                                             in_bus.block_right));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tea_variant_block_cipher_tb failed");
      $finish;
    end
  end

  initial begin
    // All block inputs are known from time zero; reset is released on a falling edge.
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op = OP_ENC;
    in_bus.block_left = '0;
    in_bus.block_right = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_KEY0;
    cfg_bus.data = '0;
    quiet_stretch = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Keys straight out of reset are all zero.
    queue_both_ops('0, '0);
    wait_for_idle();

    // Corner blocks under a random key, both operations each.
    set_key_words($urandom(), $urandom(), $urandom(), $urandom());
    queue_both_ops(32'h0000_0000, 32'h0000_0000);
    queue_both_ops(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_both_ops(32'h8000_0000, 32'h0000_0001);
    queue_both_ops(32'h0000_0001, 32'h8000_0000);
    queue_both_ops(32'hFFFF_FFFF, 32'h0000_0000);
    queue_both_ops(32'h0000_0000, 32'hFFFF_FFFF);
    queue_both_ops(32'hAAAA_AAAA, 32'h5555_5555);
    queue_round_trip(OP_ENC, $urandom(), $urandom());
    wait_for_idle();

    // Writes outside the key file must leave the keys alone.
    write_reg(RegUnusedLow, $urandom());
    write_reg(RegUnusedHigh, $urandom());
    queue_block(OP_ENC, $urandom(), $urandom(), 1'b0);
    queue_block(OP_DEC, $urandom(), $urandom(), 1'b0);
    wait_for_idle();

    // Random phases under several keys, the extremes among them. The long
    // receiver stall falls into the first one.
    set_key_words($urandom(), $urandom(), $urandom(), $urandom());
    run_random_phase(300);
    wait_for_idle();

    set_key_words('1, '1, '1, '1);
    run_random_phase(200);
    wait_for_idle();

    set_key_words('0, '0, '0, '0);
    run_random_phase(200);
    wait_for_idle();

    set_key_words(32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    run_random_phase(200);
    wait_for_idle();

    set_key_words($urandom(), $urandom(), $urandom(), $urandom());
    run_random_phase(200);
    wait_for_idle();

    // Let any stray output item surface before the verdict.
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("tea_variant_block_cipher_tb passed");
    end else begin
      $display("tea_variant_block_cipher_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/teav_pkg.sv
rtl/teav_in_if.sv
rtl/teav_out_if.sv
rtl/teav_cfg_if.sv
rtl/teav_key_regs.sv
rtl/teav_half_round.sv
rtl/tea_variant_block_cipher.sv
bench/tea_variant_block_cipher_tb.sv
